>>> rtl/wbma_pkg.sv
// ----------------------------------------------------------------------------
// wbma_pkg
// Types, constants and the saturating add shared by the moment accumulator.
// ----------------------------------------------------------------------------
package wbma_pkg;

  localparam int FRAC       = 16;
  localparam int ACC_W      = 64;
  localparam int SLICE_BITS = 10;
  localparam int NSUMS      = 13;
  localparam int NSQ        = 7;
  localparam int SW         = ACC_W + 2;
  localparam int DVD_W      = ACC_W + 2 * FRAC;
  localparam int IT_W       = $clog2(DVD_W);

  localparam logic [1:0] OP_PART  = 2'd0;
  localparam logic [1:0] OP_CLOSE = 2'd1;
  localparam logic [1:0] OP_TOTAL = 2'd2;
  localparam logic [1:0] OP_SPARE = 2'd3;

  localparam logic [3:0] IDX_WSUM  = 4'd0;
  localparam logic [3:0] IDX_LSUM  = 4'd12;
  localparam logic [3:0] IDX_COUNT = 4'd13;

  localparam logic [9:0]       TAG_MASK = 10'((32'd1 << SLICE_BITS) - 32'd1);
  localparam logic [ACC_W-1:0] ACC_MAX  = {1'b0, {(ACC_W - 1){1'b1}}};
  localparam logic [ACC_W-1:0] ACC_MIN  = {1'b1, {(ACC_W - 1){1'b0}}};
  localparam logic [63:0]      POS_LIM  = 64'((65'd1 << (ACC_W - 1)) - 65'd1);
  localparam logic [63:0]      NEG_LIM  = 64'(65'd1 << (ACC_W - 1));
  localparam logic [63:0]      ONE_W    = 64'd1 << FRAC;
  localparam logic [63:0]      ONE_SQ   = 64'd1 << (2 * FRAC);

  typedef struct packed {
    logic [1:0]         op;
    logic               particle_valid;
    logic [31:0]        weight;
    logic signed [31:0] pos_x;
    logic signed [31:0] pos_y;
    logic signed [31:0] mom_x;
    logic signed [31:0] mom_y;
    logic signed [31:0] mom_z;
    logic [9:0]         slice_index;
  } in_t;

  typedef struct packed {
    logic [9:0]         slice_tag;
    logic               is_total;
    logic [3:0]         moment_index;
    logic signed [63:0] moment_value;
    logic               saturated;
    logic               last;
  } out_t;

  typedef enum logic [1:0] {
    KIND_PART,
    KIND_CLOSE,
    KIND_TOTAL
  } kind_t;

  // One classified work item: magnitudes and signs already split
  typedef struct packed {
    kind_t       kind;
    logic [31:0] w;
    logic [31:0] ax;
    logic [31:0] ay;
    logic [31:0] aux;
    logic [31:0] auy;
    logic [31:0] auz;
    logic        sx;
    logic        sy;
    logic        sux;
    logic        suy;
    logic [9:0]  tag;
  } item_t;

  // Add a signed value to an accumulator, clamp to its range; MSB flags a clip
  function automatic logic [ACC_W:0] sat_add(input logic [ACC_W-1:0] acc,
                                             input logic [SW-1:0] val);
    logic signed [SW-1:0] s;
    logic signed [SW-1:0] mx;
    logic signed [SW-1:0] mn;
    s  = $signed({{2{acc[ACC_W-1]}}, acc}) + $signed(val);
    mx = $signed({2'b00, ACC_MAX});
    mn = $signed({2'b11, ACC_MIN});
    if (s > mx) begin
      return {1'b1, ACC_MAX};
    end else if (s < mn) begin
      return {1'b1, ACC_MIN};
    end
    return {1'b0, s[ACC_W-1:0]};
  endfunction

  // Sign-extend an accumulator value to the 64-bit result field
  function automatic logic [63:0] sext64(input logic [ACC_W-1:0] x);
    logic signed [ACC_W-1:0] t;
    t = $signed(x);
    return 64'(t);
  endfunction

endpackage

>>> rtl/wbma_queue.sv
// ----------------------------------------------------------------------------
// wbma_queue
// Two-entry queue of classified items between the front and the back end.
// ----------------------------------------------------------------------------
module wbma_queue (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           push,
  input  wbma_pkg::item_t push_item,
  output logic           full,
  output logic           not_empty,
  input  logic           pop,
  output wbma_pkg::item_t pop_item
);
  import wbma_pkg::*;

  item_t      ent_r [2];
  logic       wp_r;
  logic       rp_r;
  logic [1:0] cnt_r;
  logic [1:0] cnt_nxt;
  logic       do_push;
  logic       do_pop;

  assign full      = (cnt_r == 2'd2);
  assign not_empty = (cnt_r != 2'd0);
  assign pop_item  = ent_r[rp_r];
  assign do_push   = push && !full;
  assign do_pop    = pop && not_empty;

  always_comb begin
    cnt_nxt = cnt_r;
    if (do_push && !do_pop) begin
      cnt_nxt = cnt_r + 2'd1;
    end else if (do_pop && !do_push) begin
      cnt_nxt = cnt_r - 2'd1;
    end
  end

  // Advance pointers and count
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= 1'b0;
      rp_r  <= 1'b0;
      cnt_r <= 2'd0;
    end else begin
      cnt_r <= cnt_nxt;
      if (do_push) begin
        wp_r <= ~wp_r;
      end
      if (do_pop) begin
        rp_r <= ~rp_r;
      end
    end
  end

  // Store entries
  always_ff @(posedge clk) begin
    if (do_push) begin
      ent_r[wp_r] <= push_item;
    end
  end

endmodule

>>> rtl/wbma_front.sv
// ----------------------------------------------------------------------------
// wbma_front
// Accepts input beats, drops skipped particles and unused codes, splits
// coordinates into magnitude and sign and hands items to the queue.
// ----------------------------------------------------------------------------
module wbma_front (
  input  logic            in_valid,
  output logic            in_stall,
  input  wbma_pkg::in_t   in_data,
  input  logic            q_full,
  output logic            q_push,
  output wbma_pkg::item_t q_item
);
  import wbma_pkg::*;

  logic keep;

  assign in_stall = q_full;

  // Classify the beat
  always_comb begin
    q_item = '0;
    keep   = 1'b0;
    case (in_data.op)
      OP_PART: begin
        keep        = in_data.particle_valid;
        q_item.kind = KIND_PART;
      end
      OP_CLOSE: begin
        keep        = 1'b1;
        q_item.kind = KIND_CLOSE;
        q_item.tag  = in_data.slice_index & TAG_MASK;
      end
      OP_TOTAL: begin
        keep        = 1'b1;
        q_item.kind = KIND_TOTAL;
      end
      default: begin
        keep = 1'b0;
      end
    endcase
    q_item.w   = in_data.weight;
    q_item.sx  = in_data.pos_x[31];
    q_item.sy  = in_data.pos_y[31];
    q_item.sux = in_data.mom_x[31];
    q_item.suy = in_data.mom_y[31];
    q_item.ax  = in_data.pos_x[31] ? 32'(-in_data.pos_x) : 32'(in_data.pos_x);
    q_item.ay  = in_data.pos_y[31] ? 32'(-in_data.pos_y) : 32'(in_data.pos_y);
    q_item.aux = in_data.mom_x[31] ? 32'(-in_data.mom_x) : 32'(in_data.mom_x);
    q_item.auy = in_data.mom_y[31] ? 32'(-in_data.mom_y) : 32'(in_data.mom_y);
    q_item.auz = in_data.mom_z[31] ? 32'(-in_data.mom_z) : 32'(in_data.mom_z);
  end

  assign q_push = in_valid && !q_full && keep;

endmodule

>>> rtl/wbma_back.sv
// ----------------------------------------------------------------------------
// wbma_back
// Sequencer around one 32x32 multiplier, a square-root and a divider
// recurrence: accumulates particles, emits slice and run reports.
// ----------------------------------------------------------------------------
module wbma_back (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            q_valid,
  input  wbma_pkg::item_t q_item,
  output logic            q_pop,
  output logic            out_valid,
  input  logic            out_stall,
  output wbma_pkg::out_t  out_data
);
  import wbma_pkg::*;

  typedef enum logic [3:0] {
    ST_IDLE, ST_SQ, ST_SUM, ST_ROOT, ST_ACC,
    ST_PREP, ST_DIV, ST_FIN, ST_PUT, ST_FOLD, ST_CLR
  } state_t;

  state_t           state_r;
  item_t            it_r;
  logic [3:0]       k_r;
  logic [1:0]       sub_r;
  logic [IT_W-1:0]  cyc_r;
  logic [63:0]      sq_r [NSQ];
  logic [63:0]      sr_r;
  logic [63:0]      s_r;
  logic [35:0]      srem_r;
  logic [31:0]      g_r;
  logic [63:0]      mul_r;
  logic [63:0]      lo_r;
  logic [63:0]      term_r;
  logic             tneg_r;
  logic [ACC_W-1:0] slice_sums_r [NSUMS];
  logic [ACC_W-1:0] run_sums_r [NSUMS];
  logic [31:0]      slice_cnt_r;
  logic [31:0]      run_cnt_r;
  logic             sflag_r;
  logic             rflag_r;
  logic             src_run_r;
  logic [ACC_W-1:0] wsum_r;
  logic [DVD_W-1:0] dvd_r;
  logic [ACC_W-1:0] drem_r;
  logic [63:0]      q_r;
  logic             big_r;
  logic             dneg_r;
  logic [63:0]      val_r;
  logic             out_valid_r;
  out_t             out_r;

  logic [31:0]      mul_a;
  logic [31:0]      mul_b;
  logic [63:0]      m_k;
  logic             sh_k;
  logic             neg_k;
  logic [95:0]      full;
  logic [95:0]      full_sh;
  logic [63:0]      lim;
  logic [63:0]      clip;
  logic [SW-1:0]    tval;
  logic [ACC_W:0]   acc_res;
  logic [ACC_W:0]   fold_res;
  logic [ACC_W-1:0] cur_sum;
  logic [ACC_W-1:0] cur_mag;
  logic [31:0]      cur_cnt;
  logic             cur_flag;
  logic [35:0]      srem_sh;
  logic [35:0]      strial;
  logic [ACC_W-1:0] drem_sh;
  logic [63:0]      qlim;
  logic [63:0]      qclip;
  logic [32:0]      cnt_sum;
  logic             slot_free;

  assign out_valid = out_valid_r;
  assign out_data  = out_r;
  assign slot_free = !out_valid_r || !out_stall;
  assign q_pop     = (state_r == ST_IDLE) && q_valid;

  // Select the multiplicand of the running sum
  always_comb begin
    m_k   = '0;
    sh_k  = 1'b0;
    neg_k = 1'b0;
    case (k_r)
      4'd0:  m_k = ONE_W;
      4'd1:  begin m_k = 64'(it_r.ax);  neg_k = it_r.sx;  end
      4'd2:  begin m_k = sq_r[0]; sh_k = 1'b1; end
      4'd3:  begin m_k = 64'(it_r.ay);  neg_k = it_r.sy;  end
      4'd4:  begin m_k = sq_r[1]; sh_k = 1'b1; end
      4'd5:  begin m_k = 64'(it_r.aux); neg_k = it_r.sux; end
      4'd6:  begin m_k = sq_r[2]; sh_k = 1'b1; end
      4'd7:  begin m_k = 64'(it_r.auy); neg_k = it_r.suy; end
      4'd8:  begin m_k = sq_r[3]; sh_k = 1'b1; end
      4'd9:  begin m_k = sq_r[5]; sh_k = 1'b1; neg_k = it_r.sx ^ it_r.sux; end
      4'd10: begin m_k = sq_r[6]; sh_k = 1'b1; neg_k = it_r.sy ^ it_r.suy; end
      4'd11: m_k = 64'(g_r);
      4'd12: begin m_k = s_r; sh_k = 1'b1; end
      default: m_k = '0;
    endcase
  end

  // Route multiplier operands
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    if (state_r == ST_SQ) begin
      case (k_r)
        4'd0: begin mul_a = it_r.ax;  mul_b = it_r.ax;  end
        4'd1: begin mul_a = it_r.ay;  mul_b = it_r.ay;  end
        4'd2: begin mul_a = it_r.aux; mul_b = it_r.aux; end
        4'd3: begin mul_a = it_r.auy; mul_b = it_r.auy; end
        4'd4: begin mul_a = it_r.auz; mul_b = it_r.auz; end
        4'd5: begin mul_a = it_r.ax;  mul_b = it_r.aux; end
        4'd6: begin mul_a = it_r.ay;  mul_b = it_r.auy; end
        default: begin mul_a = '0; mul_b = '0; end
      endcase
    end else if (state_r == ST_ACC) begin
      mul_b = it_r.w;
      mul_a = (sub_r == 2'd0) ? m_k[31:0] : m_k[63:32];
    end
  end

  // Combine partial products, clip the term and add it
  always_comb begin
    full    = {mul_r, 32'b0} + {32'b0, lo_r};
    full_sh = sh_k ? (full >> FRAC) : full;
    lim     = tneg_r ? NEG_LIM : POS_LIM;
    clip    = (term_r > lim) ? lim : term_r;
    tval    = tneg_r ? SW'(-{2'b00, clip}) : SW'({2'b00, clip});
    acc_res = sat_add(slice_sums_r[k_r], tval);
  end

  // Report source, fold add and recurrence steps
  always_comb begin
    cur_sum  = (k_r < 4'(NSUMS)) ?
               (src_run_r ? run_sums_r[k_r] : slice_sums_r[k_r]) : '0;
    cur_mag  = cur_sum[ACC_W-1] ? -cur_sum : cur_sum;
    cur_cnt  = src_run_r ? run_cnt_r : slice_cnt_r;
    cur_flag = src_run_r ? rflag_r : sflag_r;
    fold_res = sat_add(run_sums_r[k_r],
                       {{2{slice_sums_r[k_r][ACC_W-1]}}, slice_sums_r[k_r]});
    cnt_sum  = {1'b0, run_cnt_r} + {1'b0, slice_cnt_r};
    srem_sh  = {srem_r[33:0], sr_r[63:62]};
    strial   = {2'b00, g_r, 2'b01};
    drem_sh  = {drem_r[ACC_W-2:0], dvd_r[DVD_W-1]};
    qlim     = dneg_r ? NEG_LIM : POS_LIM;
    qclip    = (big_r || (q_r > qlim)) ? qlim : q_r;
  end

  // Multiplier output register
  always_ff @(posedge clk) begin
    mul_r <= mul_a * mul_b;
  end

  // Sequencer: state, sums and output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      k_r         <= '0;
      sub_r       <= '0;
      cyc_r       <= '0;
      slice_cnt_r <= '0;
      run_cnt_r   <= '0;
      sflag_r     <= 1'b0;
      rflag_r     <= 1'b0;
      src_run_r   <= 1'b0;
      out_valid_r <= 1'b0;
      for (int i = 0; i < NSUMS; i++) begin
        slice_sums_r[i] <= '0;
        run_sums_r[i]   <= '0;
      end
    end else begin
      // Drop the result once taken, unless a new beat replaces it
      if (out_valid_r && !out_stall && (state_r != ST_PUT)) begin
        out_valid_r <= 1'b0;
      end
      case (state_r)
        ST_IDLE: begin
          if (q_valid) begin
            it_r <= q_item;
            k_r  <= '0;
            case (q_item.kind)
              KIND_PART:  state_r <= ST_SQ;
              KIND_CLOSE: begin src_run_r <= 1'b0; state_r <= ST_PREP; end
              KIND_TOTAL: begin src_run_r <= 1'b1; state_r <= ST_PREP; end
              default:    state_r <= ST_IDLE;
            endcase
          end
        end
        // Seven products, each stored in the cycle after its issue
        ST_SQ: begin
          if (k_r != 4'd0) begin
            sq_r[3'(k_r - 4'd1)] <= mul_r;
          end
          if (k_r == 4'(NSQ)) begin
            state_r <= ST_SUM;
          end else begin
            k_r <= k_r + 4'd1;
          end
        end
        ST_SUM: begin
          s_r     <= ONE_SQ + sq_r[2] + sq_r[3] + sq_r[4];
          sr_r    <= ONE_SQ + sq_r[2] + sq_r[3] + sq_r[4];
          srem_r  <= '0;
          g_r     <= '0;
          cyc_r   <= '0;
          state_r <= ST_ROOT;
        end
        // Square root, one result bit per cycle
        ST_ROOT: begin
          sr_r <= sr_r << 2;
          if (srem_sh >= strial) begin
            srem_r <= srem_sh - strial;
            g_r    <= {g_r[30:0], 1'b1};
          end else begin
            srem_r <= srem_sh;
            g_r    <= {g_r[30:0], 1'b0};
          end
          if (cyc_r == IT_W'(31)) begin
            k_r     <= '0;
            sub_r   <= '0;
            state_r <= ST_ACC;
          end else begin
            cyc_r <= cyc_r + IT_W'(1);
          end
        end
        // Per sum: low product, high product, combine, add
        ST_ACC: begin
          case (sub_r)
            2'd0: sub_r <= 2'd1;
            2'd1: begin
              lo_r  <= mul_r;
              sub_r <= 2'd2;
            end
            2'd2: begin
              term_r <= (|full_sh[95:64]) ? '1 : full_sh[63:0];
              tneg_r <= neg_k;
              sub_r  <= 2'd3;
            end
            default: begin
              slice_sums_r[k_r] <= acc_res[ACC_W-1:0];
              sflag_r <= sflag_r | (term_r > lim) | acc_res[ACC_W] |
                         ((k_r == IDX_LSUM) && (slice_cnt_r == '1));
              sub_r <= 2'd0;
              if (k_r == IDX_LSUM) begin
                if (slice_cnt_r != '1) begin
                  slice_cnt_r <= slice_cnt_r + 32'd1;
                end
                state_r <= ST_IDLE;
              end else begin
                k_r <= k_r + 4'd1;
              end
            end
          endcase
        end
        // Pick the next report value or start a division
        ST_PREP: begin
          if (k_r == IDX_WSUM) begin
            wsum_r  <= cur_sum;
            val_r   <= sext64(cur_sum);
            state_r <= ST_PUT;
          end else if (k_r == IDX_COUNT) begin
            val_r   <= 64'(cur_cnt);
            state_r <= ST_PUT;
          end else if (wsum_r[ACC_W-1] || (wsum_r == '0)) begin
            val_r   <= '0;
            state_r <= ST_PUT;
          end else begin
            dvd_r   <= {cur_mag, {(2 * FRAC){1'b0}}};
            drem_r  <= '0;
            q_r     <= '0;
            big_r   <= 1'b0;
            dneg_r  <= cur_sum[ACC_W-1];
            cyc_r   <= '0;
            state_r <= ST_DIV;
          end
        end
        // Restoring division, one quotient bit per cycle
        ST_DIV: begin
          dvd_r <= dvd_r << 1;
          big_r <= big_r | q_r[63];
          if (drem_sh >= wsum_r) begin
            drem_r <= drem_sh - wsum_r;
            q_r    <= {q_r[62:0], 1'b1};
          end else begin
            drem_r <= drem_sh;
            q_r    <= {q_r[62:0], 1'b0};
          end
          if (cyc_r == IT_W'(DVD_W - 1)) begin
            state_r <= ST_FIN;
          end else begin
            cyc_r <= cyc_r + IT_W'(1);
          end
        end
        ST_FIN: begin
          val_r   <= dneg_r ? -qclip : qclip;
          state_r <= ST_PUT;
        end
        // Hand one result beat to the output register
        ST_PUT: begin
          if (slot_free) begin
            out_valid_r        <= 1'b1;
            out_r.slice_tag    <= src_run_r ? 10'd0 : it_r.tag;
            out_r.is_total     <= src_run_r;
            out_r.moment_index <= k_r;
            out_r.moment_value <= val_r;
            out_r.saturated    <= cur_flag;
            out_r.last         <= (k_r == IDX_COUNT);
            if (k_r == IDX_COUNT) begin
              k_r     <= '0;
              state_r <= src_run_r ? ST_CLR : ST_FOLD;
            end else begin
              k_r     <= k_r + 4'd1;
              state_r <= ST_PREP;
            end
          end
        end
        // Fold the slice into the run totals, one sum per cycle
        ST_FOLD: begin
          run_sums_r[k_r]   <= fold_res[ACC_W-1:0];
          slice_sums_r[k_r] <= '0;
          if (k_r == IDX_LSUM) begin
            rflag_r <= rflag_r | fold_res[ACC_W] | sflag_r | cnt_sum[32];
            run_cnt_r   <= cnt_sum[32] ? '1 : cnt_sum[31:0];
            slice_cnt_r <= '0;
            sflag_r     <= 1'b0;
            state_r     <= ST_IDLE;
          end else begin
            rflag_r <= rflag_r | fold_res[ACC_W];
            k_r     <= k_r + 4'd1;
          end
        end
        ST_CLR: begin
          for (int i = 0; i < NSUMS; i++) begin
            run_sums_r[i] <= '0;
          end
          run_cnt_r <= '0;
          rflag_r   <= 1'b0;
          state_r   <= ST_IDLE;
        end
        default: state_r <= ST_IDLE;
      endcase
    end
  end

endmodule

>>> rtl/weighted_beam_moment_accumulator.sv
// ----------------------------------------------------------------------------
// weighted_beam_moment_accumulator
// Weighted beam moments per slice and per run with saturating sums.
// ----------------------------------------------------------------------------
//  channel  direction  payload  handshake
//  in_      input      in_t     in_valid / in_stall
//  out_     output     out_t    out_valid / out_stall
//
//  A valid particle passes through the back end as a pop, seven products (five
//  squares, two cross products) on the shared 32x32 multiplier, a sum, a
//  32-step square root and, per sum, a low product, a high product, a combine
//  and an add. A close or totals item emits 14 beats; with a positive weight
//  sum each of the 12 means runs the divider recurrence. Skipped particles and
//  unused codes are taken with no effect while the queue is not full. Reset
//  is synchronous and clears all sums, counts and flags at once. A two-entry
//  queue lets the input keep flowing while results stall, until it fills.
// ----------------------------------------------------------------------------
module weighted_beam_moment_accumulator (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           in_valid,
  output logic           in_stall,
  input  wbma_pkg::in_t  in_data,
  output logic           out_valid,
  input  logic           out_stall,
  output wbma_pkg::out_t out_data
);
  import wbma_pkg::*;

  logic  q_full;
  logic  q_push;
  item_t push_item;
  logic  q_valid;
  logic  q_pop;
  item_t pop_item;

  wbma_front u_front (
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_data  (in_data),
    .q_full   (q_full),
    .q_push   (q_push),
    .q_item   (push_item)
  );

  wbma_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (q_push),
    .push_item (push_item),
    .full      (q_full),
    .not_empty (q_valid),
    .pop       (q_pop),
    .pop_item  (pop_item)
  );

  wbma_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .q_valid   (q_valid),
    .q_item    (pop_item),
    .q_pop     (q_pop),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

endmodule
